/* rtl/assert_macros.svh */
// Assertion shorthands for the checker. Both forms sample on clk and stay quiet in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define JPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define JPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/jpt_pkg.sv */
// ---------------------------------------------------------------------------
// jpt_pkg: shared types and helpers
// Datapath command and status words, MAC phases and the fixed-point helpers.
// ---------------------------------------------------------------------------
package jpt_pkg;

  localparam int unsigned SWEEP_W = 8;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_RESID,
    OP_PIVOT,
    OP_NORM,
    OP_SQ1,
    OP_SQ2,
    OP_ROOT_R,
    OP_DIV,
    OP_ROOT_C,
    OP_ROOT_S,
    OP_ROT,
    OP_MAC,
    OP_COPY,
    OP_CHECK,
    OP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    PH_NT,
    PH_B,
    PH_W
  } mac_phase_t;

  typedef struct packed {
    dp_op_t     op;
    mac_phase_t phase;
    logic [1:0] r;
    logic [1:0] c;
    logic [1:0] k;
    logic       first;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic e_zero;
    logic big_hi;
    logic big_lo;
    logic root_busy;
    logic div_busy;
    logic grew;
    logic below;
  } dp_sts_t;

  // Row-major index of element (r, c).
  function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
    return ({2'b00, r} * 4'd3) + {2'b00, c};
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Shift right by 30, rounding half away from zero.
  function automatic logic signed [65:0] shr30(input logic signed [65:0] v);
    logic [65:0] m;
    m = v[65] ? 66'(-v) : 66'(v);
    m = (m + (66'd1 << 29)) >> 30;
    return v[65] ? -$signed(m) : $signed(m);
  endfunction

endpackage

/* rtl/jpt_in_if.sv */
// ---------------------------------------------------------------------------
// jpt_in_if: input tensor channel
// Valid/ready channel carrying the nine Q16.16 elements of one tensor.
// ---------------------------------------------------------------------------
interface jpt_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

/* rtl/jpt_out_if.sv */
// ---------------------------------------------------------------------------
// jpt_out_if: result row channel
// Valid/ready channel carrying one row of the rotated tensor and transform.
// ---------------------------------------------------------------------------
interface jpt_out_if;
  logic valid;
  logic ready;
  logic [1:0] row_index;
  logic signed [31:0] rot_col0, rot_col1, rot_col2;
  logic signed [31:0] xf_col0, xf_col1, xf_col2;
  logic [31:0] residual;
  logic last_row;

  modport source (output valid, row_index, rot_col0, rot_col1, rot_col2,
                  xf_col0, xf_col1, xf_col2, residual, last_row, input ready);
  modport sink   (input valid, row_index, rot_col0, rot_col1, rot_col2,
                  xf_col0, xf_col1, xf_col2, residual, last_row, output ready);
endinterface

/* rtl/jacobi_principal_tensor_3x3.sv */
// ---------------------------------------------------------------------------
// jacobi_principal_tensor_3x3: principal-axis rotation of a 3x3 tensor
// Jacobi sweeps on one Q16.16 tensor; emits rotated tensor, transform, residual.
// ---------------------------------------------------------------------------
// One tensor is taken at a time: in_ch.ready is high only while the block is
// idle, and the next tensor is taken once the third result word has been
// accepted. A tensor whose off-diagonal sum is already below tolerance skips
// the sweeps. Otherwise a sweep with a nonzero pivot runs three 32-step square
// roots on the shared root unit, a 31-step restoring divider, up to 29
// normalize shifts, and 81 multiply-accumulates on the single 35x35 multiplier
// (three matrix products of 27 terms, each followed by a pipe drain). A sweep
// whose pivot is already zero skips the rotation build. At the default sweep
// limit of 150 sweeps run at most per tensor, plus three output words.
// Tolerance is written through cfg_we/cfg_wdata and must only change while the
// block is idle.
module jacobi_principal_tensor_3x3 #(
  parameter int unsigned MAX_SWEEPS = 150
) (
  input  logic        clk,
  input  logic        rst,
  jpt_in_if.sink      in_ch,
  jpt_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata
);

  jpt_pkg::dp_cmd_t   cmd;
  jpt_pkg::dp_sts_t   sts;
  logic signed [31:0] in_a [9];
  logic [1:0]         out_row;
  logic signed [31:0] out_rot [3];
  logic signed [31:0] out_xf [3];
  logic [31:0]        out_res;

  // Flatten the input word into row-major order.
  assign in_a[0] = in_ch.a00;
  assign in_a[1] = in_ch.a01;
  assign in_a[2] = in_ch.a02;
  assign in_a[3] = in_ch.a10;
  assign in_a[4] = in_ch.a11;
  assign in_a[5] = in_ch.a12;
  assign in_a[6] = in_ch.a20;
  assign in_a[7] = in_ch.a21;
  assign in_a[8] = in_ch.a22;

  jpt_ctrl #(
    .MAX_SWEEPS (MAX_SWEEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  jpt_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_a      (in_a),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .out_row   (out_row),
    .out_rot   (out_rot),
    .out_xf    (out_xf),
    .out_res   (out_res)
  );

  // Drive the result word from the output register.
  assign out_ch.row_index = out_row;
  assign out_ch.rot_col0  = out_rot[0];
  assign out_ch.rot_col1  = out_rot[1];
  assign out_ch.rot_col2  = out_rot[2];
  assign out_ch.xf_col0   = out_xf[0];
  assign out_ch.xf_col1   = out_xf[1];
  assign out_ch.xf_col2   = out_xf[2];
  assign out_ch.residual  = out_res;
  assign out_ch.last_row  = out_row == 2'd2;

endmodule

/* rtl/jpt_root.sv */
// ---------------------------------------------------------------------------
// jpt_root: iterative integer square root
// Floor square root of a 64-bit value, two radicand bits per cycle.
// ---------------------------------------------------------------------------
module jpt_root (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] arg,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic [63:0] trial;
  logic        ge;

  assign trial = res + bitv;
  assign ge    = v >= trial;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      v    <= arg;
      res  <= '0;
      bitv <= 64'd1 << 62;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (ge) begin
        v   <= v - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* rtl/jpt_dpath.sv */
// ---------------------------------------------------------------------------
// jpt_dpath: Jacobi datapath
// Tensor, transform and rotation storage, rotation builder, divider, MAC pipe.
// ---------------------------------------------------------------------------
module jpt_dpath (
  input  logic               clk,
  input  logic               rst,
  input  jpt_pkg::dp_cmd_t   cmd,
  input  logic signed [31:0] in_a [9],
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata,
  output jpt_pkg::dp_sts_t   sts,
  output logic [1:0]         out_row,
  output logic signed [31:0] out_rot [3],
  output logic signed [31:0] out_xf [3],
  output logic [31:0]        out_res
);

  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  logic signed [31:0] orig [9];
  logic signed [31:0] w    [9];
  logic signed [31:0] t    [9];
  logic signed [31:0] nt   [9];
  logic signed [31:0] rot  [9];
  logic signed [33:0] bm   [9];

  logic [30:0] tol;
  logic [33:0] err;
  logic [33:0] off_sum;
  logic [31:0] o01, o12, o02;

  logic [1:0]  pi, pj;
  logic [31:0] old_mag;
  logic        e_zero_r;
  logic        e_neg;
  logic signed [32:0] d_reg;
  logic [32:0] dm, em, big;
  logic [63:0] sq;
  logic [30:0] sq_in;
  logic [61:0] sq_mul;

  logic        root_start;
  logic [63:0] root_arg;
  logic        root_busy;
  logic [31:0] root_res;

  logic [31:0] div_r, rem;
  logic [30:0] num_lo, quo;
  logic [4:0]  div_cnt;
  logic        div_busy;
  logic [32:0] div_t;
  logic        div_ge;

  logic [30:0] qc;
  logic [29:0] cc_c, cc;
  logic [30:0] c_val;
  logic [30:0] s_val;
  logic        s_neg;

  // Pivot selection on the current work tensor.
  logic [1:0]  sel_i, sel_j;
  logic [31:0] sel_old;
  logic signed [31:0] sel_e;
  logic signed [32:0] sel_d;

  // MAC pipe.
  logic signed [34:0] mac_a, mac_b;
  logic                     p1_v, p1_first, p1_last;
  jpt_pkg::mac_phase_t      p1_ph;
  logic [3:0]               p1_dst;
  logic signed [34:0]       p1_a, p1_b;
  logic signed [69:0]       prod_full;
  logic                     p2_v, p2_first, p2_last;
  jpt_pkg::mac_phase_t      p2_ph;
  logic [3:0]               p2_dst;
  logic signed [65:0]       p2_prod;
  logic                     p3_v, p3_first, p3_last;
  jpt_pkg::mac_phase_t      p3_ph;
  logic [3:0]               p3_dst;
  logic signed [65:0]       p3_term;
  logic                     p4_v;
  jpt_pkg::mac_phase_t      p4_ph;
  logic [3:0]               p4_dst;
  logic signed [65:0]       acc;
  logic signed [65:0]       acc_sh;

  logic [3:0] ra, rb;

  jpt_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .arg   (root_arg),
    .busy  (root_busy),
    .root  (root_res)
  );

  assign o01 = jpt_pkg::mag32(w[1]);
  assign o02 = jpt_pkg::mag32(w[2]);
  assign o12 = jpt_pkg::mag32(w[5]);
  assign off_sum = {2'b00, o01} + {2'b00, o02} + {2'b00, o12};

  always_comb begin
    if (o01 >= o12 && o01 >= o02) begin
      sel_i = 2'd0; sel_j = 2'd1; sel_old = o01;
    end else if (o12 >= o01 && o12 >= o02) begin
      sel_i = 2'd1; sel_j = 2'd2; sel_old = o12;
    end else begin
      sel_i = 2'd0; sel_j = 2'd2; sel_old = o02;
    end
    sel_e = w[jpt_pkg::idx3(sel_i, sel_j)];
    sel_d = 33'(w[jpt_pkg::idx3(sel_j, sel_j)]) - 33'(w[jpt_pkg::idx3(sel_i, sel_i)]);
  end

  assign big    = (dm > em) ? dm : em;
  assign sq_in  = (cmd.op == jpt_pkg::OP_SQ1) ? dm[30:0] : em[30:0];
  assign sq_mul = sq_in * sq_in;

  assign div_t  = {rem, num_lo[30]};
  assign div_ge = div_t >= {1'b0, div_r};

  assign qc   = (quo > 31'h40000000) ? 31'h40000000 : quo;
  assign cc_c = 30'((31'h40000000 - qc) >> 1);

  assign s_val = root_res[30:0];
  assign s_neg = (d_reg != '0) && (d_reg[32] != e_neg);

  assign root_start = (cmd.op == jpt_pkg::OP_ROOT_R) || (cmd.op == jpt_pkg::OP_ROOT_C) ||
                      (cmd.op == jpt_pkg::OP_ROOT_S);

  always_comb begin
    case (cmd.op)
      jpt_pkg::OP_ROOT_R: root_arg = sq;
      jpt_pkg::OP_ROOT_C: root_arg = {4'b0, cc_c, 30'b0};
      jpt_pkg::OP_ROOT_S: root_arg = {3'b0, 31'(31'h40000000 - {1'b0, cc}), 30'b0};
      default:            root_arg = sq;
    endcase
  end

  assign sts.e_zero    = e_zero_r;
  assign sts.big_hi    = big[32:31] != 2'b00;
  assign sts.big_lo    = big[32:30] == 3'b000;
  assign sts.root_busy = root_busy;
  assign sts.div_busy  = div_busy;
  assign sts.grew      = jpt_pkg::mag32(w[jpt_pkg::idx3(pi, pj)]) > old_mag;
  assign sts.below     = off_sum < {3'b000, tol};

  // MAC operand selection.
  always_comb begin
    ra = jpt_pkg::idx3(cmd.r, cmd.k);
    case (cmd.phase)
      jpt_pkg::PH_NT: begin
        rb    = jpt_pkg::idx3(cmd.k, cmd.c);
        mac_a = 35'(rot[ra]);
        mac_b = 35'(t[rb]);
      end
      jpt_pkg::PH_B: begin
        rb    = jpt_pkg::idx3(cmd.c, cmd.k);
        mac_a = 35'(orig[ra]);
        mac_b = 35'(t[rb]);
      end
      default: begin
        rb    = jpt_pkg::idx3(cmd.k, cmd.c);
        mac_a = 35'(t[ra]);
        mac_b = 35'(bm[rb]);
      end
    endcase
  end

  assign prod_full = p1_a * p1_b;
  assign acc_sh    = jpt_pkg::shr30(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      tol      <= 31'd66;
      div_busy <= 1'b0;
      div_cnt  <= '0;
      p1_v     <= 1'b0;
      p2_v     <= 1'b0;
      p3_v     <= 1'b0;
      p4_v     <= 1'b0;
    end else begin
      if (cfg_we) begin
        tol <= cfg_wdata;
      end

      // Pipe advance.
      p1_v     <= cmd.op == jpt_pkg::OP_MAC;
      p1_ph    <= cmd.phase;
      p1_first <= cmd.first;
      p1_last  <= cmd.last;
      p1_dst   <= jpt_pkg::idx3(cmd.r, cmd.c);
      p1_a     <= mac_a;
      p1_b     <= mac_b;
      p2_v     <= p1_v;
      p2_ph    <= p1_ph;
      p2_first <= p1_first;
      p2_last  <= p1_last;
      p2_dst   <= p1_dst;
      p2_prod  <= $signed(prod_full[65:0]);
      p3_v     <= p2_v;
      p3_ph    <= p2_ph;
      p3_first <= p2_first;
      p3_last  <= p2_last;
      p3_dst   <= p2_dst;
      p3_term  <= (p2_ph == jpt_pkg::PH_W) ? jpt_pkg::shr30(p2_prod) : p2_prod;
      p4_v     <= p3_v && p3_last;
      p4_ph    <= p3_ph;
      p4_dst   <= p3_dst;
      if (p3_v) begin
        acc <= p3_first ? p3_term : acc + p3_term;
      end

      // Write back finished sums.
      if (p4_v) begin
        case (p4_ph)
          jpt_pkg::PH_NT: begin
            if (acc_sh > 66'sd1073741824) nt[p4_dst] <= ONE_Q30;
            else if (acc_sh < -66'sd1073741824) nt[p4_dst] <= -ONE_Q30;
            else nt[p4_dst] <= acc_sh[31:0];
          end
          jpt_pkg::PH_B: begin
            if (acc_sh > 66'sd8589934591) bm[p4_dst] <= 34'sd8589934591;
            else if (acc_sh < -66'sd8589934591) bm[p4_dst] <= -34'sd8589934591;
            else bm[p4_dst] <= acc_sh[33:0];
          end
          default: begin
            if (acc > 66'sd2147483647) w[p4_dst] <= 32'sh7fffffff;
            else if (acc < -66'sd2147483648) w[p4_dst] <= 32'sh80000000;
            else w[p4_dst] <= acc[31:0];
          end
        endcase
      end

      // Divider steps.
      if (div_busy) begin
        rem     <= div_ge ? 32'(div_t - {1'b0, div_r}) : div_t[31:0];
        num_lo  <= num_lo << 1;
        quo     <= {quo[29:0], div_ge};
        div_cnt <= div_cnt + 5'd1;
        if (div_cnt == 5'd30) begin
          div_busy <= 1'b0;
        end
      end

      case (cmd.op)
        jpt_pkg::OP_LOAD: begin
          for (int n = 0; n < 9; n++) begin
            orig[n] <= in_a[n];
            w[n]    <= in_a[n];
            t[n]    <= (n % 4 == 0) ? ONE_Q30 : 32'sd0;
          end
        end
        jpt_pkg::OP_RESID: begin
          err <= off_sum;
        end
        jpt_pkg::OP_PIVOT: begin
          pi       <= sel_i;
          pj       <= sel_j;
          old_mag  <= sel_old;
          e_zero_r <= sel_e == 32'sd0;
          e_neg    <= sel_e[31];
          d_reg    <= sel_d;
          dm       <= sel_d[32] ? 33'(-sel_d) : 33'(sel_d);
          em       <= {jpt_pkg::mag32(sel_e), 1'b0};
          for (int n = 0; n < 9; n++) begin
            rot[n] <= (n % 4 == 0) ? ONE_Q30 : 32'sd0;
          end
        end
        jpt_pkg::OP_NORM: begin
          if (sts.big_hi) begin
            dm <= dm >> 1;
            em <= em >> 1;
          end else begin
            dm <= dm << 1;
            em <= em << 1;
          end
        end
        jpt_pkg::OP_SQ1: begin
          sq <= 64'(sq_mul);
        end
        jpt_pkg::OP_SQ2: begin
          sq <= sq + 64'(sq_mul);
        end
        jpt_pkg::OP_DIV: begin
          div_r    <= root_res;
          rem      <= {2'b00, dm[30:1]};
          num_lo   <= {dm[0], 30'b0};
          quo      <= '0;
          div_cnt  <= '0;
          div_busy <= 1'b1;
        end
        jpt_pkg::OP_ROOT_C: begin
          cc <= cc_c;
        end
        jpt_pkg::OP_ROOT_S: begin
          c_val <= root_res[30:0];
        end
        jpt_pkg::OP_ROT: begin
          rot[jpt_pkg::idx3(pi, pi)] <= $signed({1'b0, c_val});
          rot[jpt_pkg::idx3(pj, pj)] <= $signed({1'b0, c_val});
          if (s_neg) begin
            rot[jpt_pkg::idx3(pi, pj)] <= -$signed({1'b0, s_val});
            rot[jpt_pkg::idx3(pj, pi)] <= $signed({1'b0, s_val});
          end else begin
            rot[jpt_pkg::idx3(pi, pj)] <= $signed({1'b0, s_val});
            rot[jpt_pkg::idx3(pj, pi)] <= -$signed({1'b0, s_val});
          end
        end
        jpt_pkg::OP_COPY: begin
          for (int n = 0; n < 9; n++) begin
            t[n] <= nt[n];
          end
        end
        jpt_pkg::OP_CHECK: begin
          // Keep the prior residual when the shear grew.
          if (!sts.grew) begin
            err <= off_sum;
          end
        end
        jpt_pkg::OP_OUT: begin
          out_row <= cmd.r;
          for (int n = 0; n < 3; n++) begin
            out_rot[n] <= w[jpt_pkg::idx3(cmd.r, 2'(n))];
            out_xf[n]  <= t[jpt_pkg::idx3(cmd.r, 2'(n))];
          end
          out_res <= (err[33:32] != 2'b00) ? 32'hffffffff : err[31:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/jpt_ctrl.sv */
// ---------------------------------------------------------------------------
// jpt_ctrl: Jacobi sequencer
// Steps the datapath through load, sweeps, stop tests and the three result rows.
// ---------------------------------------------------------------------------
module jpt_ctrl #(
  parameter int unsigned MAX_SWEEPS = 150
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_ready,
  input  jpt_pkg::dp_sts_t  sts,
  output logic              in_ready,
  output logic              out_valid,
  output jpt_pkg::dp_cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_RESID  = 14'b00000000000010,
    S_PIVOT  = 14'b00000000000100,
    S_NORM   = 14'b00000000001000,
    S_SQ2    = 14'b00000000010000,
    S_ROOT_R = 14'b00000000100000,
    S_WAIT_R = 14'b00000001000000,
    S_WAIT_D = 14'b00000010000000,
    S_WAIT_C = 14'b00000100000000,
    S_WAIT_S = 14'b00001000000000,
    S_MAC    = 14'b00010000000000,
    S_DRAIN  = 14'b00100000000000,
    S_CHECK  = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t                 state, state_next;
  jpt_pkg::mac_phase_t    phase, phase_next;
  logic [1:0]             r, r_next, c, c_next, k, k_next;
  logic [2:0]             drain, drain_next;
  logic [jpt_pkg::SWEEP_W-1:0] sweep, sweep_next;
  logic [jpt_pkg::SWEEP_W:0]   sweep_inc;
  logic                   valid_next;

  assign in_ready  = state == S_IDLE;
  assign sweep_inc = {1'b0, sweep} + 1'b1;

  always_comb begin
    state_next = state;
    phase_next = phase;
    r_next     = r;
    c_next     = c;
    k_next     = k;
    drain_next = drain;
    sweep_next = sweep;
    valid_next = out_valid;
    cmd        = '0;
    cmd.op     = jpt_pkg::OP_NOP;
    cmd.phase  = phase;
    cmd.r      = r;
    cmd.c      = c;
    cmd.k      = k;
    cmd.first  = k == 2'd0;
    cmd.last   = k == 2'd2;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = jpt_pkg::OP_LOAD;
          state_next = S_RESID;
        end
      end
      S_RESID: begin
        cmd.op     = jpt_pkg::OP_RESID;
        sweep_next = '0;
        state_next = sts.below ? S_OUT : S_PIVOT;
      end
      S_PIVOT: begin
        cmd.op     = jpt_pkg::OP_PIVOT;
        state_next = S_NORM;
      end
      S_NORM: begin
        if (sts.e_zero) begin
          // Identity rotation: go straight to the products.
          phase_next = jpt_pkg::PH_NT;
          state_next = S_MAC;
        end else if (sts.big_hi || sts.big_lo) begin
          cmd.op = jpt_pkg::OP_NORM;
        end else begin
          cmd.op     = jpt_pkg::OP_SQ1;
          state_next = S_SQ2;
        end
      end
      S_SQ2: begin
        cmd.op     = jpt_pkg::OP_SQ2;
        state_next = S_ROOT_R;
      end
      S_ROOT_R: begin
        cmd.op     = jpt_pkg::OP_ROOT_R;
        state_next = S_WAIT_R;
      end
      S_WAIT_R: begin
        if (!sts.root_busy) begin
          cmd.op     = jpt_pkg::OP_DIV;
          state_next = S_WAIT_D;
        end
      end
      S_WAIT_D: begin
        if (!sts.div_busy) begin
          cmd.op     = jpt_pkg::OP_ROOT_C;
          state_next = S_WAIT_C;
        end
      end
      S_WAIT_C: begin
        if (!sts.root_busy) begin
          cmd.op     = jpt_pkg::OP_ROOT_S;
          state_next = S_WAIT_S;
        end
      end
      S_WAIT_S: begin
        if (!sts.root_busy) begin
          cmd.op     = jpt_pkg::OP_ROT;
          phase_next = jpt_pkg::PH_NT;
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        cmd.op = jpt_pkg::OP_MAC;
        k_next = k + 2'd1;
        if (k == 2'd2) begin
          k_next = '0;
          c_next = c + 2'd1;
          if (c == 2'd2) begin
            c_next = '0;
            r_next = r + 2'd1;
            if (r == 2'd2) begin
              r_next     = '0;
              drain_next = '0;
              state_next = S_DRAIN;
            end
          end
        end
      end
      S_DRAIN: begin
        // Hold until the last sum of the phase is written back.
        drain_next = drain + 3'd1;
        if (drain == 3'd4) begin
          case (phase)
            jpt_pkg::PH_NT: begin
              cmd.op     = jpt_pkg::OP_COPY;
              phase_next = jpt_pkg::PH_B;
              state_next = S_MAC;
            end
            jpt_pkg::PH_B: begin
              phase_next = jpt_pkg::PH_W;
              state_next = S_MAC;
            end
            default: begin
              state_next = S_CHECK;
            end
          endcase
        end
      end
      S_CHECK: begin
        cmd.op     = jpt_pkg::OP_CHECK;
        sweep_next = sweep_inc[jpt_pkg::SWEEP_W-1:0];
        if (sts.grew || sts.below ||
            sweep_inc == (jpt_pkg::SWEEP_W+1)'(MAX_SWEEPS)) begin
          state_next = S_OUT;
        end else begin
          state_next = S_PIVOT;
        end
      end
      S_OUT: begin
        if (!out_valid) begin
          cmd.op     = jpt_pkg::OP_OUT;
          cmd.r      = 2'd0;
          r_next     = 2'd0;
          valid_next = 1'b1;
        end else if (out_ready) begin
          if (r == 2'd2) begin
            r_next     = '0;
            valid_next = 1'b0;
            state_next = S_IDLE;
          end else begin
            cmd.op = jpt_pkg::OP_OUT;
            cmd.r  = r + 2'd1;
            r_next = r + 2'd1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= jpt_pkg::PH_NT;
      r         <= '0;
      c         <= '0;
      k         <= '0;
      drain     <= '0;
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      r         <= r_next;
      c         <= c_next;
      k         <= k_next;
      drain     <= drain_next;
      sweep     <= sweep_next;
      out_valid <= valid_next;
    end
  end

endmodule

/* rtl/jpt_checker.sv */
// ---------------------------------------------------------------------------
// jpt_checker: port-level checks
// Watches the channels of the top level for row ordering and one-at-a-time use.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jpt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] row_index,
  input logic       last_row
);

  `JPT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(row_index), "result word dropped or changed while stalled")
  `JPT_ASSERT_NXT(a_row_next, out_valid && out_ready && !last_row, out_valid && (row_index == $past(row_index) + 2'd1), "rows not back to back in order")
  `JPT_ASSERT_IMP(a_last_row, out_valid, last_row == (row_index == 2'd2), "last_row not on row two")
  `JPT_ASSERT_NXT(a_in_busy, in_valid && in_ready, !out_valid && !in_ready, "new tensor taken while busy")

endmodule

bind jacobi_principal_tensor_3x3 jpt_checker u_jpt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .row_index (out_ch.row_index),
  .last_row  (out_ch.last_row)
);

/* sim/tb_jacobi_principal_tensor_3x3.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_jacobi_principal_tensor_3x3: self-checking bench for the Jacobi tensor block
// Drives 3x3 Q16.16 tensors through the input channel under random bursts,
// computes every expected result row with an in-bench fixed-point Jacobi
// solver, and compares each accepted result word field by field.
// ---------------------------------------------------------------------------
module tb_jacobi_principal_tensor_3x3;

  localparam int           SWEEP_LIMIT = 150;
  localparam longint       Q30_ONE     = 64'sd1 << 30;
  localparam logic [30:0]  TOL_RESET   = 31'd66;

  typedef logic [8:0][31:0] tensor_t;

  typedef struct packed {
    logic [1:0]  row;
    logic [31:0] rot0, rot1, rot2;
    logic [31:0] xf0, xf1, xf2;
    logic [31:0] resid;
    logic        last;
  } row_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we;
  logic [30:0] cfg_wdata;

  jpt_in_if  in_ch ();
  jpt_out_if out_ch ();

  jacobi_principal_tensor_3x3 DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  tensor_t     pending_tensors[$];   // waiting to be offered
  row_word_t   expected_rows[$];     // predicted words, oldest first
  logic [30:0] tol_now = TOL_RESET;  // bench copy of the tolerance register
  bit          failed = 0;
  int          rows_seen = 0;

  // -------------------------------------------------------------------------
  // Fixed-point helpers for the solver
  // -------------------------------------------------------------------------
  function automatic longint unsigned mag(input longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // Shift right by 30, rounding half away from zero.
  function automatic longint rshift30(input longint v);
    longint unsigned m;
    m = (mag(v) + (64'd1 << 29)) >> 30;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Jacobi solver: rotate one tensor and queue its three result words
  // -------------------------------------------------------------------------
  task automatic solve_tensor(input tensor_t t, input logic [30:0] tol);
    longint orig[9], w[9], xf[9], rot[9], nt[9], b[9];
    longint d, e, c, s, cc, q, acc;
    longint unsigned dm, em, big, r, err, o01, o12, o02, old;
    int pi, pj, i, j, n, sweep;
    row_word_t rw;
    for (i = 0; i < 9; i++) begin
      orig[i] = longint'($signed(t[i]));
      w[i]    = orig[i];
      xf[i]   = (i % 4 == 0) ? Q30_ONE : 0;
    end
    err = mag(w[1]) + mag(w[2]) + mag(w[5]);
    if (err >= tol) begin
      for (sweep = 0; sweep < SWEEP_LIMIT; sweep++) begin
        // pick the pivot, ties favor 01, then 12, then 02
        o01 = mag(w[1]);
        o12 = mag(w[5]);
        o02 = mag(w[2]);
        if (o01 >= o12 && o01 >= o02) begin
          pi = 0; pj = 1; old = o01;
        end else if (o12 >= o01 && o12 >= o02) begin
          pi = 1; pj = 2; old = o12;
        end else begin
          pi = 0; pj = 2; old = o02;
        end
        for (i = 0; i < 9; i++) rot[i] = (i % 4 == 0) ? Q30_ONE : 0;
        e = w[pi*3 + pj];
        if (e != 0) begin
          d  = w[pj*4] - w[pi*4];
          dm = mag(d);
          em = mag(e) << 1;
          big = dm > em ? dm : em;
          while (big >= (64'd1 << 31)) begin
            big >>= 1; dm >>= 1; em >>= 1;
          end
          while (big < (64'd1 << 30)) begin
            big <<= 1; dm <<= 1; em <<= 1;
          end
          r  = int_sqrt(dm*dm + em*em);
          q  = longint'((dm << 30) / r);
          if (q > Q30_ONE) q = Q30_ONE;
          cc = (Q30_ONE - q) >>> 1;
          c  = longint'(int_sqrt(longint'(cc) << 30));
          s  = longint'(int_sqrt(longint'(Q30_ONE - cc) << 30));
          // flip the sine when the diagonal gap and the shear disagree in sign
          if (d != 0 && ((d < 0) != (e < 0))) s = -s;
          rot[pi*4]       = c;
          rot[pj*4]       = c;
          rot[pi*3 + pj]  = s;
          rot[pj*3 + pi]  = -s;
        end
        for (i = 0; i < 3; i++)
          for (j = 0; j < 3; j++) begin
            acc = 0;
            for (n = 0; n < 3; n++) acc += rot[i*3+n] * xf[n*3+j];
            nt[i*3+j] = clip(rshift30(acc), -Q30_ONE, Q30_ONE);
          end
        xf = nt;
        for (n = 0; n < 3; n++)
          for (j = 0; j < 3; j++) begin
            acc = 0;
            for (i = 0; i < 3; i++) acc += orig[n*3+i] * xf[j*3+i];
            b[n*3+j] = clip(rshift30(acc), -((64'sd1 << 33) - 1), (64'sd1 << 33) - 1);
          end
        for (i = 0; i < 3; i++)
          for (j = 0; j < 3; j++) begin
            acc = 0;
            for (n = 0; n < 3; n++) acc += rshift30(xf[i*3+n] * b[n*3+j]);
            w[i*3+j] = clip(acc, -64'sd2147483648, 64'sd2147483647);
          end
        // shear grew: stop and keep the prior residual
        if (mag(w[pi*3+pj]) > old) break;
        err = mag(w[1]) + mag(w[2]) + mag(w[5]);
        if (err < tol) break;
      end
    end
    for (i = 0; i < 3; i++) begin
      rw.row   = 2'(i);
      rw.rot0  = w[i*3][31:0];
      rw.rot1  = w[i*3+1][31:0];
      rw.rot2  = w[i*3+2][31:0];
      rw.xf0   = xf[i*3][31:0];
      rw.xf1   = xf[i*3+1][31:0];
      rw.xf2   = xf[i*3+2][31:0];
      rw.resid = err > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : err[31:0];
      rw.last  = (i == 2);
      expected_rows.push_back(rw);
    end
  endtask

  // -------------------------------------------------------------------------
  // Driver: offer tensors in bursts, predict each one on acceptance
  // -------------------------------------------------------------------------
  int burst_left = 4;
  int gap_left   = 0;

  always @(posedge clk) begin
    logic taken;
    taken = in_ch.valid && in_ch.ready;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (taken) begin
        solve_tensor(pending_tensors.pop_front(), tol_now);
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 6);
          // leave some bursts back to back
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      if (in_ch.valid && !taken) begin
        // hold the offered word until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_tensors.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.a00 <= pending_tensors[0][0];
        in_ch.a01 <= pending_tensors[0][1];
        in_ch.a02 <= pending_tensors[0][2];
        in_ch.a10 <= pending_tensors[0][3];
        in_ch.a11 <= pending_tensors[0][4];
        in_ch.a12 <= pending_tensors[0][5];
        in_ch.a20 <= pending_tensors[0][6];
        in_ch.a21 <= pending_tensors[0][7];
        in_ch.a22 <= pending_tensors[0][8];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: stall on a rotating mask, check each accepted word
  // -------------------------------------------------------------------------
  logic [15:0] stall_mask = 16'hFFFF;
  logic [3:0]  stall_pos  = 0;
  int          hold_cnt   = 0;
  bit          hold_done  = 0;

  always @(posedge clk) begin
    row_word_t want, got;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.row_index, out_ch.rot_col0, out_ch.rot_col1, out_ch.rot_col2,
                out_ch.xf_col0, out_ch.xf_col1, out_ch.xf_col2, out_ch.residual,
                out_ch.last_row};
        rows_seen++;
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected word %p", $realtime, got);
          failed = 1;
        end else begin
          want = expected_rows.pop_front();
          if (got.row !== want.row)
            $display("%0t: row_index exp %0d got %0d", $realtime, want.row, got.row);
          if (got.rot0 !== want.rot0)
            $display("%0t: rot_col0 exp %h got %h", $realtime, want.rot0, got.rot0);
          if (got.rot1 !== want.rot1)
            $display("%0t: rot_col1 exp %h got %h", $realtime, want.rot1, got.rot1);
          if (got.rot2 !== want.rot2)
            $display("%0t: rot_col2 exp %h got %h", $realtime, want.rot2, got.rot2);
          if (got.xf0 !== want.xf0)
            $display("%0t: xf_col0 exp %h got %h", $realtime, want.xf0, got.xf0);
          if (got.xf1 !== want.xf1)
            $display("%0t: xf_col1 exp %h got %h", $realtime, want.xf1, got.xf1);
          if (got.xf2 !== want.xf2)
            $display("%0t: xf_col2 exp %h got %h", $realtime, want.xf2, got.xf2);
          if (got.resid !== want.resid)
            $display("%0t: residual exp %h got %h", $realtime, want.resid, got.resid);
          if (got.last !== want.last)
            $display("%0t: last_row exp %b got %b", $realtime, want.last, got.last);
          if (got !== want) failed = 1;
        end
      end
      // once, early on, back off for a long stretch so the input stalls
      if (!hold_done && rows_seen == 6) begin
        hold_done = 1;
        hold_cnt  = 3000;
      end
      if (hold_cnt > 0) hold_cnt--;
      stall_pos <= stall_pos + 1'b1;
      if (stall_pos == 4'hF) begin
        case ($urandom_range(0, 3))
          0: stall_mask <= 16'hFFFF;
          1: stall_mask <= 16'($urandom);
          2: stall_mask <= 16'($urandom | $urandom);
          default: stall_mask <= 16'($urandom & $urandom);
        endcase
      end
      out_ch.ready <= (hold_cnt == 0) && stall_mask[stall_pos];
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  function automatic logic [31:0] rand_elem();
    int wid;
    wid = $urandom_range(1, 32);
    return 32'($signed($urandom) >>> (32 - wid));
  endfunction

  // Mostly symmetric tensors; the rest fully random.
  function automatic tensor_t rand_tensor();
    tensor_t t;
    for (int k = 0; k < 9; k++) t[k] = rand_elem();
    if ($urandom_range(0, 4) != 0) begin
      t[3] = t[1];
      t[6] = t[2];
      t[7] = t[5];
    end
    return t;
  endfunction

  function automatic tensor_t sym(input logic [31:0] d0, d1, d2, o01, o02, o12);
    return {d2, o12, o02, o12, d1, o01, o02, o01, d0};
  endfunction

  task automatic wait_idle();
    while (pending_tensors.size() != 0 || in_ch.valid || expected_rows.size() != 0)
      @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_tol(input logic [30:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    tol_now    = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_random(input int count);
    repeat (count) pending_tensors.push_back(rand_tensor());
  endtask

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.a00, in_ch.a01, in_ch.a02, in_ch.a10, in_ch.a11} = '0;
    {in_ch.a12, in_ch.a20, in_ch.a21, in_ch.a22} = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed set at the reset tolerance
    pending_tensors.push_back('0);                                   // zero tensor
    pending_tensors.push_back(sym(32'h10000, 32'h20000, 32'h30000, 0, 0, 0));  // diagonal
    pending_tensors.push_back({9{32'h7FFF_FFFF}});                   // all max
    pending_tensors.push_back({9{32'h8000_0000}});                   // all min
    pending_tensors.push_back(sym(32'h7FFF_FFFF, 32'h8000_0000, 0,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_tensors.push_back(sym(32'h20000, 32'h20000, 32'h20000,
                                  32'h10000, 32'h10000, 32'h10000));  // three-way tie
    pending_tensors.push_back(sym(32'h20000, 32'h50000, 32'h10000,
                                  0, 32'h8000, 32'h8000));            // tie 12 vs 02
    pending_tensors.push_back(sym(32'h40000, 32'h40000, 32'h10000,
                                  32'hFFFF_0000, 0, 0));              // equal diagonal
    pending_tensors.push_back(sym(32'h10000, 32'h50000, 0,
                                  32'hFFFE_0000, 0, 0));              // opposite signs
    pending_tensors.push_back(sym(32'h50000, 32'h10000, 0,
                                  32'hFFFE_0000, 0, 0));              // same signs
    pending_tensors.push_back(sym(0, 0, 32'h30000, 0, 32'h0001_0000, 0)); // only 02
    pending_tensors.push_back(sym(32'hFFF0_0000, 32'h0010_0000, 32'h1,
                                  32'h1, 32'h2, 32'h3));              // tiny shears
    pending_tensors.push_back({32'h1, 32'h2, 32'h3, 32'h4, 32'h5,
                               32'h6, 32'h7, 32'h8, 32'h9});          // non-symmetric
    pending_tensors.push_back(sym(32'h7FFF_FFFF, 32'h8000_0001, 32'h0,
                                  32'h4000_0000, 32'hC000_0000, 32'h1234_5678));
    add_random(6);
    wait_idle();

    // zero tolerance: sweeps stop only at the sweep limit or when the shear grows
    write_tol('0);
    pending_tensors.push_back(sym(32'h30000, 32'h10000, 32'h20000,
                                  32'h8000, 32'h4000, 32'h2000));
    add_random(1);
    wait_idle();

    // top tolerance: an off-diagonal sum below 31'h7FFF_FFFF counts as already diagonal
    write_tol(31'h7FFF_FFFF);
    add_random(4);
    wait_idle();

    write_tol(31'h1_0000);
    add_random(40);
    wait_idle();

    write_tol(31'($urandom_range(1, 5000)));
    add_random(45);
    wait_idle();

    write_tol(TOL_RESET);
    add_random(50);
    wait_idle();

    repeat (100) @(posedge clk);
    if (!failed) $display("jacobi_principal_tensor_3x3 verification clean");
    else $display("jacobi_principal_tensor_3x3 verification failed");
    $finish;
  end

  // guard: ends the run if the block hangs
  initial begin
    #60_000_000;
    $display("jacobi_principal_tensor_3x3 verification failed");
    $finish;
  end

endmodule
